// ----- sv/i2a_pkg.sv -----
`default_nettype none

package i2a_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned RADIX_W  = 5;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned MAX_DIG  = 32;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned CNT_W    = 6;

    localparam int unsigned DIV_BITS  = 4;
    localparam int unsigned DIV_STEPS = VALUE_W / DIV_BITS;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO       = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE = 7'd87;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS      = 7'd45;
    localparam logic [RADIX_W-1:0] SIGNED_BASE     = 5'd10;
    localparam logic [RADIX_W-1:0] MIN_BASE        = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_BASE        = 5'd16;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } div_res_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10)
        begin
            return CHAR_ZERO + dx;
        end
        return CHAR_ALPHA_BASE + dx;
    endfunction

endpackage

`default_nettype wire

// ----- sv/i2a_divider.sv -----
`default_nettype none

module i2a_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        dividend,
    input  wire logic [4:0]         base,
    output i2a_pkg::div_res_t       res
);
    import i2a_pkg::*;

    // restoring division, four quotient bits per cycle

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   q_reg, q_next;
    logic [RADIX_W-1:0]   r_reg, r_next;
    logic [RADIX_W-1:0]   base_reg, base_next;

    logic [VALUE_W-1:0] q_step;
    logic [RADIX_W-1:0] r_step;

    always_comb
    begin
        logic [VALUE_W-1:0] q;
        logic [RADIX_W-1:0] r;
        q = q_reg;
        r = r_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r = {r[RADIX_W-2:0], q[VALUE_W-1]};
            q = {q[VALUE_W-2:0], 1'b0};
            if (r >= base_reg)
            begin
                r    = r - base_reg;
                q[0] = 1'b1;
            end
        end
        q_step = q;
        r_step = r;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        base_next = base_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            base_next = base;
        end
        else if (busy_reg)
        begin
            q_next   = q_step;
            r_next   = r_step;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        base_reg <= base_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = q_reg;
    assign res.remainder = r_reg[DIGIT_W-1:0];

endmodule

`default_nettype wire

// ----- sv/integer_to_ascii_converter.sv -----
// Each digit takes a start, a division and a store, then characters follow one per cycle
// while out_ready allows; 1 to 32 output transactions per input.
// A new input is accepted only in idle, once the last character is in the output register.
// The single 4-bit-per-cycle restoring divider, reused for every digit, limits throughput.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and
// empties the output register.
`default_nettype none

module integer_to_ascii_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] value,
    input  wire logic [4:0]  radix,
    input  wire logic        signed_mode,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [6:0]       digit_char,
    output logic             is_last
);
    import i2a_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [RADIX_W-1:0] base_reg, base_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   nd_reg, nd_next;
    logic               oval_reg, oval_next;
    logic [CHAR_W-1:0]  ochar_reg, ochar_next;
    logic               olast_reg, olast_next;

    // digit stack: newest (most significant) digit sits at the top
    logic [DIGIT_W-1:0] digits [MAX_DIG];
    logic               div_start;
    div_res_t           div_res;
    logic [CNT_W-1:0]   nd_m1;
    logic [RADIX_W-1:0] in_base;
    logic               slot_free;
    logic               push_dig;
    logic               pop_dig;

    i2a_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (val_reg),
        .base     (base_reg),
        .res      (div_res)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_START);
    assign nd_m1     = nd_reg - 6'd1;
    assign slot_free = !oval_reg || out_ready;
    assign push_dig  = (state_reg == ST_WAIT) && div_res.done;
    assign pop_dig   = (state_reg == ST_EMIT) && slot_free && !neg_reg;

    always_comb
    begin
        if (signed_mode)
        begin
            in_base = SIGNED_BASE;
        end
        else if (radix < MIN_BASE)
        begin
            in_base = MIN_BASE;
        end
        else if (radix > MAX_BASE)
        begin
            in_base = MAX_BASE;
        end
        else
        begin
            in_base = radix;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        nd_next    = nd_reg;
        oval_next  = oval_reg && !out_ready;
        ochar_next = ochar_reg;
        olast_next = olast_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    base_next = in_base;
                    nd_next   = '0;
                    if (signed_mode && value[VALUE_W-1])
                    begin
                        neg_next = 1'b1;
                        val_next = ~value + 32'd1;
                    end
                    else
                    begin
                        neg_next = 1'b0;
                        val_next = value;
                    end
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_res.done)
                begin
                    val_next = div_res.quotient;
                    nd_next  = nd_reg + 6'd1;
                    if (div_res.quotient == '0 || nd_reg == CNT_W'(MAX_DIG - 1))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    oval_next = 1'b1;
                    if (neg_reg)
                    begin
                        ochar_next = CHAR_MINUS;
                        olast_next = 1'b0;
                        neg_next   = 1'b0;
                    end
                    else
                    begin
                        ochar_next = digit_to_char(digits[0]);
                        olast_next = (nd_reg == 6'd1);
                        nd_next    = nd_m1;
                        if (nd_reg == 6'd1)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            val_reg   <= '0;
            base_reg  <= MIN_BASE;
            neg_reg   <= 1'b0;
            nd_reg    <= '0;
            oval_reg  <= 1'b0;
            ochar_reg <= CHAR_ZERO;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            val_reg   <= val_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            nd_reg    <= nd_next;
            oval_reg  <= oval_next;
            ochar_reg <= ochar_next;
            olast_reg <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_dig)
        begin
            digits[0] <= div_res.remainder;
            for (int i = 1; i < MAX_DIG; i++)
            begin
                digits[i] <= digits[i-1];
            end
        end
        else if (pop_dig)
        begin
            for (int i = 0; i < MAX_DIG - 1; i++)
            begin
                digits[i] <= digits[i+1];
            end
        end
    end

    assign out_valid  = oval_reg;
    assign digit_char = ochar_reg;
    assign is_last    = olast_reg;

endmodule

`default_nettype wire

// ----- tb/i2a_char_checker.sv -----
module i2a_char_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] value,
    input  logic [4:0]  radix,
    input  logic        signed_mode,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  digit_char,
    input  logic        is_last,
    output int unsigned fail_count,
    output int unsigned chars_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2a_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_char_t;

    ascii_char_t expected_chars[$];

    initial
    begin
        fail_count    = 0;
        chars_waiting = 0;
    end

    function automatic logic [CHAR_W-1:0] ascii_digit(input logic [31:0] d);
        logic [CHAR_W-1:0] low;
        low = d[CHAR_W-1:0];
        if (d < 10)
        begin
            return CHAR_ZERO + low;
        end
        return CHAR_ALPHA_BASE + low;
    endfunction

    // Magnitude is split least significant digit first, then queued in print order.
    function automatic void predict_digits(input logic [31:0] v, input logic [4:0] r,
                                           input logic s);
        logic [31:0]       mag;
        logic [31:0]       base;
        logic [CHAR_W-1:0] digs [MAX_DIG];
        ascii_char_t       item;
        int                n;
        mag  = v;
        base = {27'd0, r};
        if (r < MIN_BASE)
        begin
            base = {27'd0, MIN_BASE};
        end
        if (r > MAX_BASE)
        begin
            base = {27'd0, MAX_BASE};
        end
        if (s)
        begin
            base = {27'd0, SIGNED_BASE};
            if (v[31])
            begin
                mag       = ~v + 32'd1;
                item.code = CHAR_MINUS;
                item.last = 1'b0;
                expected_chars.push_back(item);
            end
        end
        n = 0;
        do
        begin
            digs[n] = ascii_digit(mag % base);
            mag     = mag / base;
            n++;
        end
        while (mag != 0 && n < MAX_DIG);
        for (int i = n - 1; i >= 0; i--)
        begin
            item.code = digs[i];
            item.last = (i == 0);
            expected_chars.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        ascii_char_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("digit_char: no transaction expected, actual %0d", digit_char);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (digit_char !== want.code)
                    begin
                        $error("digit_char: expected %0d, actual %0d", want.code, digit_char);
                        fail_count++;
                    end
                    if (is_last !== want.last)
                    begin
                        $error("is_last: expected %0b, actual %0b", want.last, is_last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_digits(value, radix, signed_mode);
            end
        end
        chars_waiting = expected_chars.size();
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [31:0] value       = 32'd0;
    logic [4:0]  radix       = 5'd0;
    logic        signed_mode = 1'b0;
    logic        out_ready   = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [6:0]  digit_char;
    logic        is_last;
    logic        calm        = 1'b0;
    int unsigned fail_count;
    int unsigned chars_waiting;

    integer_to_ascii_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .radix       (radix),
        .signed_mode (signed_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_char  (digit_char),
        .is_last     (is_last)
    );

    i2a_char_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .radix         (radix),
        .signed_mode   (signed_mode),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digit_char    (digit_char),
        .is_last       (is_last),
        .fail_count    (fail_count),
        .chars_waiting (chars_waiting)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 22);
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_number(input logic [31:0] v, input logic [4:0] r, input logic s);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        value       <= v;
        radix       <= r;
        signed_mode <= s;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] v;
        logic [4:0]  r;
        logic        s;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_number(32'd0, 5'd10, 1'b0);
        send_number(32'd0, 5'd2, 1'b0);
        send_number(32'hFFFF_FFFF, 5'd2, 1'b0);
        send_number(32'hFFFF_FFFF, 5'd16, 1'b0);
        send_number(32'hFFFF_FFFF, 5'd10, 1'b0);
        send_number(32'hFFFF_FFFF, 5'd3, 1'b0);
        send_number(32'h8000_0000, 5'd8, 1'b0);
        send_number(32'd1, 5'd16, 1'b0);
        send_number(32'd15, 5'd16, 1'b0);
        send_number(32'hFEDC_BA98, 5'd16, 1'b0);
        send_number(32'h1234_5678, 5'd0, 1'b0);
        send_number(32'h1234_5678, 5'd1, 1'b0);
        send_number(32'd255, 5'd17, 1'b0);
        send_number(32'hABCD_0123, 5'd31, 1'b0);
        send_number(32'd35, 5'd15, 1'b0);
        send_number(32'd1_000_000_000, 5'd10, 1'b0);
        send_number(32'h8000_0000, 5'd10, 1'b1);
        send_number(32'hFFFF_FFFF, 5'd31, 1'b1);
        send_number(32'h7FFF_FFFF, 5'd2, 1'b1);
        send_number(32'd0, 5'd0, 1'b1);
        send_number(32'd12345, 5'd16, 1'b1);
        send_number(32'hFFFF_FF85, 5'd7, 1'b1);
        send_number(32'd9, 5'd9, 1'b0);

        for (int i = 0; i < 147; i++)
        begin
            calm = (i >= 60 && i < 100);
            case ($urandom_range(5))
                0: v = $urandom_range(0, 99);
                1: v = $urandom >> $urandom_range(31);
                2: v = 32'h8000_0000 + $urandom_range(0, 3) - 32'd2;
                3: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
                4: v = 32'd1 << $urandom_range(31);
                default: v = $urandom;
            endcase
            r = ($urandom_range(3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 16));
            s = $urandom_range(1);
            send_number(v, r, s);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait (chars_waiting == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
sv/i2a_pkg.sv
sv/i2a_divider.sv
sv/integer_to_ascii_converter.sv
tb/i2a_char_checker.sv
tb/tb_top.sv
